[rtl/core/trw_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// trw_pkg: shared types and constants for the text run width / hit test block
// Operation codes, glyph table constants and the table command bundle.
// ----------------------------------------------------------------------------
package trw_pkg;

   localparam int TABLE_ENTRIES = 256;
   localparam int ADDR_BITS     = 8;
   localparam int RUN_BITS      = 28;
   localparam int COUNT_BITS    = 16;
   localparam int WVAL_BITS     = 13;
   localparam int PX_BITS       = 16;

   localparam logic [ADDR_BITS-1:0] TAB_CODE     = 8'h09;
   localparam logic [ADDR_BITS-1:0] NEWLINE_CODE = 8'h0A;
   localparam logic [7:0]           CONT_MASK    = 8'hC0;
   localparam logic [7:0]           CONT_MATCH   = 8'h80;
   localparam int                   TAB_FACTOR_SHIFT = 2;  // tab = 4x fill width
   localparam int                   DEFAULT_FILL = 8;

   typedef enum logic [1:0] {
      OP_FILL = 2'd0,
      OP_SET  = 2'd1,
      OP_TEXT = 2'd2
   } op_type;

   // table command, one per accepted beat
   typedef struct packed {
      logic                        fill;
      logic                        set;
      logic                        read;
      logic [ADDR_BITS-1:0]        addr;
      logic signed [WVAL_BITS-1:0] value;
   } tbl_cmd_type;

endpackage : trw_pkg
`default_nettype wire

[rtl/core/trw_table.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// trw_table: glyph width table
// 256-entry synchronous RAM plus per-entry written bits; a fill clears the
// written bits, loads fill width; unwritten read as fill (tab 4x, newline 0).
// ----------------------------------------------------------------------------
module trw_table #(
   parameter int WIDTH_BITS = 12
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire trw_pkg::tbl_cmd_type     cmd,
   output logic [WIDTH_BITS-1:0]         glyph_width
);
   import trw_pkg::*;

   localparam int WMAX     = (1 << WIDTH_BITS) - 1;
   localparam int FILL_MAX = WMAX >> 2;
   localparam int EXT_BITS = 18;

   logic [WIDTH_BITS-1:0]    mem [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0] written_ff;
   logic [WIDTH_BITS-1:0]    fill_ff;

   logic [WIDTH_BITS-1:0]    rd_data_ff;
   logic                     rd_written_ff;
   logic [WIDTH_BITS-1:0]    rd_fill_ff;
   logic [ADDR_BITS-1:0]     rd_addr_ff;

   logic signed [EXT_BITS-1:0] wv_ext;
   logic [WIDTH_BITS-1:0]      fill_clamped;
   logic [WIDTH_BITS-1:0]      set_clamped;

   assign wv_ext = EXT_BITS'(cmd.value);

   always_comb begin
      if (wv_ext < 18'sd1) begin
         fill_clamped = WIDTH_BITS'(1);
      end else if (wv_ext > $signed(EXT_BITS'(FILL_MAX))) begin
         fill_clamped = WIDTH_BITS'(FILL_MAX);
      end else begin
         fill_clamped = wv_ext[WIDTH_BITS-1:0];
      end
      if (wv_ext < 18'sd0) begin
         set_clamped = '0;
      end else if (wv_ext > $signed(EXT_BITS'(WMAX))) begin
         set_clamped = WIDTH_BITS'(WMAX);
      end else begin
         set_clamped = wv_ext[WIDTH_BITS-1:0];
      end
   end

   // written bits and fill value
   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
         fill_ff    <= WIDTH_BITS'(DEFAULT_FILL);
      end else if (cmd.fill) begin
         written_ff <= '0;
         fill_ff    <= fill_clamped;
      end else if (cmd.set) begin
         written_ff[cmd.addr] <= 1'b1;
      end
   end

   // RAM write port
   always_ff @(posedge clock) begin
      if (cmd.set) begin
         mem[cmd.addr] <= set_clamped;
      end
   end

   // RAM read port; snapshot held until the next read
   always_ff @(posedge clock) begin
      if (cmd.read) begin
         rd_data_ff    <= mem[cmd.addr];
         rd_written_ff <= written_ff[cmd.addr];
         rd_fill_ff    <= fill_ff;
         rd_addr_ff    <= cmd.addr;
      end
   end

   always_comb begin
      if (rd_written_ff) begin
         glyph_width = rd_data_ff;
      end else if (rd_addr_ff == TAB_CODE) begin
         glyph_width = rd_fill_ff << TAB_FACTOR_SHIFT;
      end else if (rd_addr_ff == NEWLINE_CODE) begin
         glyph_width = '0;
      end else begin
         glyph_width = rd_fill_ff;
      end
   end

endmodule : trw_table
`default_nettype wire

[rtl/core/trw_run.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// trw_run: run accumulator and hit test
// Adds lead-byte widths, counts bytes, tracks the hit and the pending
// second-half candidate; clears itself after the last byte.
// ----------------------------------------------------------------------------
module trw_run #(
   parameter int WIDTH_BITS    = 12,
   parameter int MAX_RUN_BYTES = 65535
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            step,
   input  wire logic [7:0]                      text_byte,
   input  wire logic signed [trw_pkg::PX_BITS-1:0] pixel_x,
   input  wire logic                            last_byte,
   input  wire logic [WIDTH_BITS-1:0]           glyph_width,
   output logic [trw_pkg::RUN_BITS-1:0]         total_width,
   output logic [trw_pkg::COUNT_BITS-1:0]       hit_offset
);
   import trw_pkg::*;

   logic [RUN_BITS-1:0]   run_width_ff, run_width_in;
   logic [COUNT_BITS-1:0] run_count_ff, run_count_in;
   logic                  hit_found_ff, hit_found_in;
   logic [COUNT_BITS-1:0] hit_pos_ff, hit_pos_in;
   logic                  cand_ff, cand_in;
   logic                  cand_cont_ff, cand_cont_in;

   logic [RUN_BITS:0]     sum_half, sum_full, px_ext;
   logic                  is_cont, left_half, in_glyph, end_hit;

   assign is_cont  = (text_byte & CONT_MASK) == CONT_MATCH;
   assign sum_half = {1'b0, run_width_ff} + (RUN_BITS+1)'(glyph_width >> 1);
   assign sum_full = {1'b0, run_width_ff} + (RUN_BITS+1)'(glyph_width);
   assign px_ext   = (RUN_BITS+1)'(pixel_x[PX_BITS-2:0]);
   // negative positions lie left of every midpoint
   assign left_half = pixel_x[PX_BITS-1] || (px_ext < sum_half);
   assign in_glyph  = px_ext < sum_full;

   always_comb begin
      run_width_in = run_width_ff;
      hit_found_in = hit_found_ff;
      hit_pos_in   = hit_pos_ff;
      cand_in      = cand_ff;
      cand_cont_in = cand_cont_ff;

      if (is_cont) begin
         if (cand_ff) begin
            cand_cont_in = 1'b1;
         end
      end else begin
         if (!hit_found_ff && cand_ff && cand_cont_ff) begin
            hit_found_in = 1'b1;
            hit_pos_in   = run_count_ff;
         end
         cand_in      = 1'b0;
         cand_cont_in = 1'b0;
         if (!hit_found_in) begin
            if (left_half) begin
               hit_found_in = 1'b1;
               hit_pos_in   = run_count_ff;
            end else if (in_glyph) begin
               cand_in = 1'b1;
            end
         end
         run_width_in = sum_full[RUN_BITS] ? '1 : sum_full[RUN_BITS-1:0];
      end

      if (run_count_ff < COUNT_BITS'(MAX_RUN_BYTES)) begin
         run_count_in = run_count_ff + 1'b1;
      end else begin
         run_count_in = run_count_ff;
      end

      // candidate confirmed by continuation bytes resolves at run end
      end_hit     = !hit_found_in && cand_in && cand_cont_in;
      total_width = run_width_in;
      if (hit_found_in) begin
         hit_offset = hit_pos_in;
      end else begin
         hit_offset = run_count_in;
      end
      if (end_hit) begin
         hit_offset = run_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (step && last_byte)) begin
         run_width_ff <= '0;
         run_count_ff <= '0;
         hit_found_ff <= 1'b0;
         hit_pos_ff   <= '0;
         cand_ff      <= 1'b0;
         cand_cont_ff <= 1'b0;
      end else if (step) begin
         run_width_ff <= run_width_in;
         run_count_ff <= run_count_in;
         hit_found_ff <= hit_found_in;
         hit_pos_ff   <= hit_pos_in;
         cand_ff      <= cand_in;
         cand_cont_ff <= cand_cont_in;
      end
   end

endmodule : trw_run
`default_nettype wire

[rtl/core/text_run_width_and_hit_test.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// text_run_width_and_hit_test: glyph width table with UTF-8 run measure
// Measures a text run against a per-byte width table and hit tests pixel_x.
// ----------------------------------------------------------------------------
// Usage:
//  - req channel carries one beat per command: fill table (req_tuser=0),
//    set one entry (1) or one text byte (2). Code 3 is dropped.
//  - Text bytes of a run stream in; req_tlast marks the run's final byte.
//    Only that byte yields a rsp beat (total width, hit byte offset).
//  - Throughput: one beat per cycle while no last byte waits on the rsp
//    register. Each text byte does one table RAM read at acceptance and one
//    accumulate when its stage advances; the rsp register loads from the
//    accumulator when the last byte's accumulate step runs.
//  - Table writes take effect for the very next beat; a fill clears the
//    written bits at once, with no sweep.
//  - rsp stall: the rsp register holds its beat; further beats keep being
//    accepted until a second last byte needs the rsp register, then
//    req_tready drops until rsp_tready returns.
//  - Reset: table reads 8 everywhere, tab 32, newline 0; run state cleared;
//    no rsp beat pending. Block accepts beats as soon as reset is released.
// ----------------------------------------------------------------------------
module text_run_width_and_hit_test #(
   parameter int WIDTH_BITS    = 12,
   parameter int MAX_RUN_BYTES = 65535
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // req_tdata: byte_value[7:0], width_value[20:8], pixel_x[36:21], zero pad
   input  wire logic [39:0] req_tdata,
   // req_tuser: operation[1:0]
   input  wire logic [1:0]  req_tuser,
   input  wire logic        req_tlast,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // rsp_tdata: total_width[27:0], hit_offset[43:28], zero pad
   output logic [47:0]      rsp_tdata,
   output logic             rsp_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready
);
   import trw_pkg::*;

   logic                         accept;
   op_type                       op;
   tbl_cmd_type                  cmd;
   logic [WIDTH_BITS-1:0]        glyph_width;

   // accumulate stage (one text byte)
   logic                         s1_valid_ff;
   logic [7:0]                   s1_byte_ff;
   logic signed [PX_BITS-1:0]    s1_px_ff;
   logic                         s1_last_ff;
   logic                         s1_adv;

   logic [RUN_BITS-1:0]          res_width;
   logic [COUNT_BITS-1:0]        res_hit;
   logic [RUN_BITS-1:0]          rsp_width_ff;
   logic [COUNT_BITS-1:0]        rsp_hit_ff;
   logic                         rsp_valid_ff;

   assign op     = op_type'(req_tuser);
   assign accept = req_tvalid && req_tready;

   // stage holds only when its last byte finds the rsp register occupied and stalled
   assign s1_adv     = s1_valid_ff && !(s1_last_ff && rsp_valid_ff && !rsp_tready);
   assign req_tready = !s1_valid_ff || s1_adv;

   always_comb begin
      cmd.fill  = 1'b0;
      cmd.set   = 1'b0;
      cmd.read  = 1'b0;
      cmd.addr  = req_tdata[7:0];
      cmd.value = req_tdata[20:8];
      unique case (op)
         OP_FILL: cmd.fill = accept;
         OP_SET:  cmd.set  = accept;
         OP_TEXT: cmd.read = accept;
         default: ;
      endcase
   end

   trw_table #(
      .WIDTH_BITS (WIDTH_BITS)
   ) u_table (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .glyph_width (glyph_width)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (cmd.read) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read) begin
         s1_byte_ff <= req_tdata[7:0];
         s1_px_ff   <= req_tdata[36:21];
         s1_last_ff <= req_tlast;
      end
   end

   trw_run #(
      .WIDTH_BITS    (WIDTH_BITS),
      .MAX_RUN_BYTES (MAX_RUN_BYTES)
   ) u_run (
      .clock       (clock),
      .reset       (reset),
      .step        (s1_adv),
      .text_byte   (s1_byte_ff),
      .pixel_x     (s1_px_ff),
      .last_byte   (s1_last_ff),
      .glyph_width (glyph_width),
      .total_width (res_width),
      .hit_offset  (res_hit)
   );

   // rsp register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv && s1_last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && s1_last_ff) begin
         rsp_width_ff <= res_width;
         rsp_hit_ff   <= res_hit;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = 1'b1;
   assign rsp_tdata  = {4'b0, rsp_hit_ff, rsp_width_ff};

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   a_last_step_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      s1_adv && s1_last_ff |=> rsp_tvalid)
      else $error("last byte stepped without a rsp beat");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready && s1_valid_ff && s1_last_ff |-> !s1_adv)
      else $error("pending rsp beat overwritten");

   a_stall_only_when_busy: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> s1_valid_ff && s1_last_ff && rsp_valid_ff)
      else $error("req stalled without a blocked last byte");

endmodule : text_run_width_and_hit_test
`default_nettype wire

[tb/trw_run_checker.sv]
// ----------------------------------------------------------------------------
// trw_run_checker: result predictor and scoreboard for text run measure
// Watches the req and rsp channels, keeps its own glyph width table and run
// state, predicts one result per run and compares every rsp beat.
// ----------------------------------------------------------------------------
module trw_run_checker
   import trw_pkg::*;
#(
   parameter int WIDTH_BITS    = 12,
   parameter int MAX_RUN_BYTES = 65535
) (
   input  logic        clock,
   input  logic        reset,
   // req_tdata: byte_value[7:0], width_value[20:8], pixel_x[36:21], zero pad
   input  logic [39:0] req_tdata,
   // req_tuser: operation[1:0]
   input  logic [1:0]  req_tuser,
   input  logic        req_tlast,
   input  logic        req_tvalid,
   input  logic        req_tready,
   // rsp_tdata: total_width[27:0], hit_offset[43:28], zero pad
   input  logic [47:0] rsp_tdata,
   input  logic        rsp_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   output int          mismatch_count,
   output int          results_outstanding
);

   localparam longint WIDTH_MAX = (64'd1 << WIDTH_BITS) - 1;
   localparam longint FILL_MAX  = WIDTH_MAX >> 2;
   localparam longint RUN_MAX   = (64'd1 << RUN_BITS) - 1;

   typedef struct packed {
      logic [RUN_BITS-1:0]   total_width;
      logic [COUNT_BITS-1:0] hit_offset;
      logic                  last;
   } run_result_type;

   logic [WIDTH_BITS-1:0] glyph_width [TABLE_ENTRIES];
   logic [RUN_BITS-1:0]   acc_width;
   logic [COUNT_BITS-1:0] byte_count;
   logic [COUNT_BITS-1:0] hit_pos;
   bit                    hit_seen;
   bit                    cand_pending;    // pixel_x in second half of last lead
   bit                    cand_confirmed;  // ... and that glyph had a continuation
   run_result_type        run_results_q[$];

   function void clear_run();
      acc_width      = '0;
      byte_count     = '0;
      hit_pos        = '0;
      hit_seen       = 0;
      cand_pending   = 0;
      cand_confirmed = 0;
   endfunction

   function void fill_glyphs(input longint w);
      if (w < 1) w = 1;
      if (w > FILL_MAX) w = FILL_MAX;
      foreach (glyph_width[k]) glyph_width[k] = WIDTH_BITS'(w);
      glyph_width[TAB_CODE]     = WIDTH_BITS'(w << TAB_FACTOR_SHIFT);
      glyph_width[NEWLINE_CODE] = '0;
   endfunction

   function void set_glyph(input logic [7:0] idx, input longint w);
      if (w < 0) w = 0;
      if (w > WIDTH_MAX) w = WIDTH_MAX;
      glyph_width[idx] = WIDTH_BITS'(w);
   endfunction

   // one text byte: accumulate, hit test, emit the run result on its last byte
   function void measure_byte(input logic [7:0] b, input longint px, input bit is_last);
      longint         x;
      longint         w;
      run_result_type r;
      if ((b & CONT_MASK) == CONT_MATCH) begin
         if (cand_pending) cand_confirmed = 1;
      end else begin
         w = glyph_width[b];
         x = acc_width;
         if (!hit_seen && cand_pending && cand_confirmed) begin
            hit_seen = 1;
            hit_pos  = byte_count;
         end
         cand_pending   = 0;
         cand_confirmed = 0;
         if (!hit_seen) begin
            if (px < x + w / 2) begin
               hit_seen = 1;
               hit_pos  = byte_count;
            end else if (px < x + w) begin
               cand_pending = 1;
            end
         end
         acc_width = RUN_BITS'((x + w > RUN_MAX) ? RUN_MAX : x + w);
      end
      if (byte_count < MAX_RUN_BYTES) byte_count++;
      if (is_last) begin
         if (!hit_seen && cand_pending && cand_confirmed) begin
            hit_seen = 1;
            hit_pos  = byte_count;
         end
         r.total_width = acc_width;
         r.hit_offset  = hit_seen ? hit_pos : byte_count;
         r.last        = 1'b1;
         run_results_q.push_back(r);
         clear_run();
      end
   endfunction

   function void check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      run_result_type want;
      if (reset) begin
         fill_glyphs(DEFAULT_FILL);
         clear_run();
         run_results_q.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            case (req_tuser)
               OP_FILL: fill_glyphs(longint'($signed(req_tdata[20:8])));
               OP_SET:  set_glyph(req_tdata[7:0], longint'($signed(req_tdata[20:8])));
               OP_TEXT: measure_byte(req_tdata[7:0], longint'($signed(req_tdata[36:21])),
                                     req_tlast);
               default: ;  // unused code, dropped by the block
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (run_results_q.size() == 0) begin
               $error("unexpected rsp beat: total_width %0d, hit_offset %0d",
                      rsp_tdata[27:0], rsp_tdata[43:28]);
               mismatch_count++;
            end else begin
               want = run_results_q.pop_front();
               check_field("total_width", want.total_width, rsp_tdata[27:0]);
               check_field("hit_offset", want.hit_offset, rsp_tdata[43:28]);
               check_field("last", want.last, rsp_tlast);
            end
         end
      end
      results_outstanding = run_results_q.size();
   end

endmodule : trw_run_checker

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: testbench for text_run_width_and_hit_test
// Drives table commands and UTF-8 text runs with random gaps on both sides;
// the checker beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_top;
   import trw_pkg::*;

   localparam int         WIDTH_BITS    = 12;
   localparam int         MAX_RUN_BYTES = 65535;
   localparam logic [1:0] OP_UNUSED     = 2'd3;   // ignored by the block
   localparam int         RANDOM_ITEMS  = 1250;
   localparam int         CYCLE_LIMIT   = 1000000;
   localparam int         SETTLE_CYCLES = 20;

   // gap modes: no idling, full random idling, occasional idling
   localparam int GAPS_NONE   = 0;
   localparam int GAPS_FULL   = 1;
   localparam int GAPS_SPARSE = 2;

   logic        clock;
   logic        reset      = 1'b1;
   // req_tdata: byte_value[7:0], width_value[20:8], pixel_x[36:21], zero pad
   logic [39:0] req_tdata  = '0;
   // req_tuser: operation[1:0]
   logic [1:0]  req_tuser  = '0;
   logic        req_tlast  = 1'b0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // rsp_tdata: total_width[27:0], hit_offset[43:28], zero pad
   logic [47:0] rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;

   int mismatch_count;
   int results_outstanding;
   int gap_mode    = GAPS_FULL;
   int items_sent  = 0;
   int cycle_count = 0;

   text_run_width_and_hit_test #(
      .WIDTH_BITS   (WIDTH_BITS),
      .MAX_RUN_BYTES(MAX_RUN_BYTES)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .req_tlast (req_tlast),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready)
   );

   trw_run_checker #(
      .WIDTH_BITS   (WIDTH_BITS),
      .MAX_RUN_BYTES(MAX_RUN_BYTES)
   ) u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_tdata          (req_tdata),
      .req_tuser          (req_tuser),
      .req_tlast          (req_tlast),
      .req_tvalid         (req_tvalid),
      .req_tready         (req_tready),
      .rsp_tdata          (rsp_tdata),
      .rsp_tlast          (rsp_tlast),
      .rsp_tvalid         (rsp_tvalid),
      .rsp_tready         (rsp_tready),
      .mismatch_count     (mismatch_count),
      .results_outstanding(results_outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // hard stop in case a beat never arrives
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // idle cycles before the next beat, per current gap mode
   function int draw_gap();
      case (gap_mode)
         GAPS_NONE: return 0;
         GAPS_FULL: return $urandom_range(0, 18);
         default:   return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 18) : 0;
      endcase
   endfunction

   // rsp side: random stall before each beat, then hold ready until it moves
   initial begin
      int stall;
      while (reset) @(posedge clock);
      forever begin
         stall = draw_gap();
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!(rsp_tvalid && rsp_tready)) @(posedge clock);
      end
   end

   // one req beat; returns at the edge where it was taken, tvalid still high
   // so a back-to-back beat just overwrites the fields
   task send_beat(input logic [1:0] op, input logic [7:0] b,
                  input logic signed [12:0] wv, input logic signed [15:0] px,
                  input logic last);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= {3'b000, px, wv, b};
      req_tuser  <= op;
      req_tlast  <= last;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (op != OP_UNUSED) items_sent++;
   endtask

   // sender holds off until every predicted result beat has been seen;
   // the first look is at the falling edge so the last accepted beat is counted
   task wait_for_results();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (results_outstanding != 0) @(negedge clock);
      @(posedge clock);
   endtask

   // set, fill or an ignored code, all fields random where they don't matter
   task send_table_op();
      logic signed [12:0] wv;
      case ($urandom_range(0, 9))
         0: begin
            wv = ($urandom_range(0, 3) != 0) ? 13'($urandom_range(1, 40)) : 13'($urandom);
            send_beat(OP_FILL, 8'($urandom), wv, 16'($urandom), 1'($urandom_range(0, 1)));
         end
         1: send_beat(OP_UNUSED, 8'($urandom), 13'($urandom), 16'($urandom),
                      1'($urandom_range(0, 1)));
         default: begin
            wv = $urandom_range(0, 1) ? 13'($urandom_range(0, 64)) : 13'($urandom);
            send_beat(OP_SET, 8'($urandom), wv, 16'($urandom), 1'($urandom_range(0, 1)));
         end
      endcase
   endtask

   // mostly well-formed UTF-8 with random content; some stray bytes and
   // sequences cut short by the run end, now and then a table write mid-run
   task send_random_run();
      int                 run_len;
      int                 sent;
      int                 conts;
      int                 kind;
      logic signed [15:0] px;
      logic [7:0]         lead;
      sent = 0;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5, 6: run_len = $urandom_range(1, 8);
         7, 8:                run_len = $urandom_range(9, 24);
         default:             run_len = $urandom_range(25, 80);
      endcase
      // pixel_x mostly inside the run, sometimes anywhere
      if ($urandom_range(0, 3) == 0) px = 16'($urandom);
      else px = 16'(int'($urandom_range(0, run_len * 12)) - 4);
      while (sent < run_len) begin
         if ($urandom_range(0, 39) == 0) send_table_op();
         kind  = $urandom_range(0, 9);
         conts = 0;
         if (kind < 5) begin
            lead = 8'($urandom_range(8'h00, 8'h7F));
         end else if (kind < 7) begin
            lead  = 8'($urandom_range(8'hC0, 8'hDF));
            conts = 1;
         end else if (kind == 7) begin
            lead  = 8'($urandom_range(8'hE0, 8'hEF));
            conts = 2;
         end else if (kind == 8) begin
            lead  = 8'($urandom_range(8'hF0, 8'hF7));
            conts = 3;
         end else begin
            lead = 8'($urandom_range(0, 255));  // stray byte, continuation possible
         end
         send_beat(OP_TEXT, lead, 13'($urandom), px, sent == run_len - 1);
         sent++;
         while (conts > 0 && sent < run_len) begin
            send_beat(OP_TEXT, 8'($urandom_range(8'h80, 8'hBF)), 13'($urandom), px,
                      sent == run_len - 1);
            sent++;
            conts--;
         end
      end
   endtask

   initial begin
      bit drained_mid;
      drained_mid = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // ---- directed: reset table, hit rules, clamps, ignored beats ----
      gap_mode = GAPS_FULL;
      // pixel_x at its minimum: hit on the first byte; tab and newline widths
      send_beat(OP_TEXT, 8'h41, 13'sd0, 16'sh8000, 1'b0);
      send_beat(OP_TEXT, TAB_CODE, 13'sd0, 16'sh8000, 1'b0);
      send_beat(OP_TEXT, NEWLINE_CODE, 13'sd0, 16'sh8000, 1'b1);
      // second half of a two-byte glyph, confirmed, resolves at next lead
      send_beat(OP_TEXT, 8'hC3, 13'sd0, 16'sd5, 1'b0);
      send_beat(OP_TEXT, 8'hA9, 13'sd0, 16'sd5, 1'b0);
      send_beat(OP_TEXT, 8'h41, 13'sd0, 16'sd5, 1'b1);
      // confirmed candidate resolves at run end
      send_beat(OP_TEXT, 8'hE2, 13'sd0, 16'sd6, 1'b0);
      send_beat(OP_TEXT, 8'h82, 13'sd0, 16'sd6, 1'b1);
      // candidate dropped by a following lead byte
      send_beat(OP_TEXT, 8'h41, 13'sd0, 16'sd5, 1'b0);
      send_beat(OP_TEXT, 8'h42, 13'sd0, 16'sd5, 1'b1);
      // run of a single continuation byte
      send_beat(OP_TEXT, 8'h80, 13'sd0, 16'sd0, 1'b1);
      // unused code with last set: no result
      send_beat(OP_UNUSED, 8'hFF, -13'sd1, -16'sd1, 1'b1);
      // fill below the floor, last ignored on table beats
      send_beat(OP_FILL, 8'hFF, 13'sh1000, 16'sd0, 1'b1);
      // table write in the middle of a run, pixel_x at max: no hit
      send_beat(OP_TEXT, 8'hFF, 13'sd0, 16'sd32767, 1'b0);
      send_beat(OP_SET, 8'hFF, 13'sd4095, -16'sd1, 1'b0);
      send_beat(OP_TEXT, 8'hFF, 13'sd0, 16'sd32767, 1'b1);
      // fill above the ceiling; tab gets four times it
      send_beat(OP_FILL, 8'h00, 13'sd4095, 16'sd0, 1'b0);
      send_beat(OP_TEXT, TAB_CODE, 13'sd0, 16'sd32767, 1'b1);
      // set below zero, zero-width glyph
      send_beat(OP_SET, 8'h00, 13'sh1000, 16'sd0, 1'b0);
      send_beat(OP_TEXT, 8'h00, 13'sd0, 16'sd0, 1'b1);
      send_beat(OP_FILL, 8'h55, 13'sd0, 16'sd0, 1'b0);
      send_beat(OP_FILL, 8'hAA, 13'(DEFAULT_FILL), 16'sd0, 1'b0);
      send_beat(OP_TEXT, 8'h7F, 13'sd0, -16'sd1, 1'b1);

      // ---- random runs with table traffic between and within ----
      items_sent = 0;
      gap_mode   = GAPS_FULL;
      while (items_sent < RANDOM_ITEMS) begin
         if (!drained_mid && items_sent >= RANDOM_ITEMS / 2) begin
            wait_for_results();
            drained_mid = 1;
         end
         if ($urandom_range(0, 14) == 0) gap_mode = $urandom_range(GAPS_NONE, GAPS_SPARSE);
         if ($urandom_range(0, 3) == 0) send_table_op();
         send_random_run();
      end

      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule : tb_top

[files.f]
rtl/core/trw_pkg.sv
rtl/core/trw_table.sv
rtl/core/trw_run.sv
rtl/core/text_run_width_and_hit_test.sv
tb/trw_run_checker.sv
tb/tb_top.sv
